### rtl/tcu_pkg.sv
// Shared types, constants and helper functions of the tricubic upsampler.
// No dependencies; imported by tcu_if, tcu_lane and the top level.
`timescale 1ns / 1ps

package tcu_pkg;

	// grid and factor limits
	localparam int AXIS_MAX   = 16;
	localparam int FACTOR_MAX = 4;
	localparam int AXIS_W     = $clog2(AXIS_MAX);
	localparam int ADDR_W     = 3 * AXIS_W;
	localparam int SIZE_W     = 5;
	localparam int FAC_W      = 3;
	localparam int FINE_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// datapath widths
	localparam int VAL_W      = 32;
	localparam int MID_W      = 34;   // per-pass result, unsaturated
	localparam int WGT_W      = 9;    // Catmull-Rom integer weight
	localparam int PROD_W     = MID_W + WGT_W;
	localparam int ACC_W      = 42;   // dot product of four terms
	localparam int DEN_W      = 8;    // divisor 2*f^3
	localparam int DIG        = 8;    // quotient bits per divider cycle
	localparam int DIV_W      = 48;
	localparam int DIV_STEPS  = DIV_W / DIG;
	localparam int NB_DEPTH   = 64;
	localparam int NB_W       = $clog2(NB_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIZE_X,
		REG_SIZE_Y,
		REG_SIZE_Z,
		REG_FACTOR
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRAP,
		ST_GATHER,
		ST_MAC,
		ST_DIV,
		ST_STORE,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PASS_X,
		PASS_Y,
		PASS_Z
	} pass_t;

	// control word from the sequencer to both channel lanes
	typedef struct packed {
		logic              nb_we;
		logic [NB_W-1:0]   nb_waddr;
		logic [NB_W-1:0]   nb_raddr;
		pass_t             pass;
		logic [3:0]        sel_idx;
		logic              issue;
		logic              first;
		logic [WGT_W-1:0]  wgt;
		logic              div_load;
		logic              div_step;
		logic [DEN_W-1:0]  den;
		logic              store;
	} ctl_t;

	// tap weight i of fraction j/f, scaled by 2*f^3
	function automatic logic [WGT_W-1:0] catmull_weight(input logic [FAC_W-1:0] f,
		input logic [1:0] j, input logic [1:0] i);
		int a;
		int b;
		int w;
		a = int'(j);
		b = int'(f) - a;
		case (i)
			2'd0: w = -a * b * b;
			2'd1: w = b * (2 * b * b + 6 * a * b + a * a);
			2'd2: w = a * (2 * a * a + 6 * a * b + b * b);
			default: w = -a * a * b;
		endcase
		return WGT_W'(w);
	endfunction

	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
		if (s == '0)
			return SIZE_W'(1);
		if (s > SIZE_W'(AXIS_MAX))
			return SIZE_W'(AXIS_MAX);
		return s;
	endfunction

	function automatic logic [FAC_W-1:0] eff_factor(input logic [FAC_W-1:0] f);
		if (f == '0)
			return FAC_W'(1);
		if (f > FAC_W'(FACTOR_MAX))
			return FAC_W'(FACTOR_MAX);
		return f;
	endfunction

	// periodic successor on an axis of n points
	function automatic logic [AXIS_W-1:0] wrap_next(input logic [AXIS_W-1:0] c,
		input logic [SIZE_W-1:0] n);
		if (SIZE_W'(c) + SIZE_W'(1) == n)
			return '0;
		return c + AXIS_W'(1);
	endfunction

	// periodic predecessor on an axis of n points
	function automatic logic [AXIS_W-1:0] wrap_prev(input logic [AXIS_W-1:0] c,
		input logic [SIZE_W-1:0] n);
		if (c == '0)
			return AXIS_W'(n - SIZE_W'(1));
		return c - AXIS_W'(1);
	endfunction

endpackage

### rtl/tcu_if.sv
// Valid/ready channel interfaces for input words and result words.
// Depends on tcu_pkg.
`timescale 1ns / 1ps

interface tcu_item_if import tcu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     op;
	logic [AXIS_W-1:0]        coord_x;
	logic [AXIS_W-1:0]        coord_y;
	logic [AXIS_W-1:0]        coord_z;
	logic signed [VAL_W-1:0]  energy_in;
	logic signed [VAL_W-1:0]  weight_in;

	modport source(output valid, op, coord_x, coord_y, coord_z, energy_in, weight_in,
		input ready);
	modport sink(input valid, op, coord_x, coord_y, coord_z, energy_in, weight_in,
		output ready);
endinterface

interface tcu_result_if import tcu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [FINE_W-1:0]        fine_x;
	logic [FINE_W-1:0]        fine_y;
	logic [FINE_W-1:0]        fine_z;
	logic signed [VAL_W-1:0]  energy_out;
	logic signed [VAL_W-1:0]  weight_out;
	logic                     last;

	modport source(output valid, fine_x, fine_y, fine_z, energy_out, weight_out, last,
		input ready);
	modport sink(input valid, fine_x, fine_y, fine_z, energy_out, weight_out, last,
		output ready);
endinterface

### rtl/tcu_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Holds the coarse grid; no dependencies.
`timescale 1ns / 1ps

module tcu_ram #(
	parameter int DATA_W = 64,
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### rtl/tcu_lane.sv
// One channel of the interpolator: neighbor scratch, pass buffers, MAC and divider.
// Depends on tcu_pkg; driven by the sequencer in the top level.
`timescale 1ns / 1ps

module tcu_lane import tcu_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctl_t                     ctl,
	input  logic [VAL_W-1:0]         grid_rd,
	output logic signed [VAL_W-1:0]  res_sat
);

	// gathered 4x4x4 neighborhood, indexed {x, y, z}
	logic [VAL_W-1:0]         nb_mem [NB_DEPTH];
	logic [VAL_W-1:0]         nb_rd_q;
	// x-pass and y-pass results
	logic signed [MID_W-1:0]  e2_q [16];
	logic signed [MID_W-1:0]  e3_q [4];
	logic signed [MID_W-1:0]  sel_q;

	pass_t                    pass_s1;
	logic signed [WGT_W-1:0]  wgt_s1;
	logic                     first_s1, vld_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     first_s2, vld_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [MID_W-1:0]  opnd;

	logic signed [ACC_W-1:0]  half, t;
	logic [ACC_W-1:0]         mag;
	logic [DIV_W-1:0]         dv_q, dv_n, q;
	logic [DEN_W-1:0]         rem_q, rem_n, r;
	logic [DEN_W:0]           r9;
	logic                     neg_q;
	logic signed [MID_W-1:0]  qs, res;

	// scratch memory
	always_ff @(posedge clk) begin
		if (ctl.nb_we)
			nb_mem[ctl.nb_waddr] <= grid_rd;
		nb_rd_q <= nb_mem[ctl.nb_raddr];
	end

	// pass buffers: registered operand read, result write-back
	always_ff @(posedge clk) begin
		case (ctl.pass)
			PASS_Y: sel_q <= e2_q[ctl.sel_idx];
			default: sel_q <= e3_q[ctl.sel_idx[1:0]];
		endcase
		if (ctl.store) begin
			case (ctl.pass)
				PASS_X: e2_q[ctl.sel_idx] <= res;
				default: e3_q[ctl.sel_idx[1:0]] <= res;
			endcase
		end
	end

	// MAC pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			first_s1 <= 1'b0;
			first_s2 <= 1'b0;
			pass_s1  <= PASS_X;
		end else begin
			vld_s1   <= ctl.issue;
			first_s1 <= ctl.first;
			pass_s1  <= ctl.pass;
			vld_s2   <= vld_s1;
			first_s2 <= first_s1;
		end
	end

	assign opnd = (pass_s1 == PASS_X) ? MID_W'($signed(nb_rd_q)) : sel_q;

	// multiply, then accumulate
	always_ff @(posedge clk) begin
		wgt_s1  <= $signed(ctl.wgt);
		prod_s2 <= opnd * wgt_s1;
		if (vld_s2)
			acc_q <= first_s2 ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
	end

	// rounding offset and magnitude for the floor division
	assign half = $signed({{(ACC_W-DEN_W){1'b0}}, ctl.den >> 1});
	assign t    = acc_q + half;
	assign mag  = t[ACC_W-1] ? ACC_W'(-t) : ACC_W'(t);

	// restoring division, DIG quotient bits per cycle
	always_comb begin
		r = rem_q;
		q = dv_q;
		r9 = '0;
		for (int b = 0; b < DIG; b++) begin
			r9 = {r, q[DIV_W-1]};
			q = {q[DIV_W-2:0], 1'b0};
			if (r9 >= {1'b0, ctl.den}) begin
				r9 = r9 - {1'b0, ctl.den};
				q[0] = 1'b1;
			end
			r = r9[DEN_W-1:0];
		end
		rem_n = r;
		dv_n = q;
	end

	always_ff @(posedge clk) begin
		if (ctl.div_load) begin
			dv_q  <= {{(DIV_W-ACC_W){1'b0}}, mag};
			neg_q <= t[ACC_W-1];
			rem_q <= '0;
		end else if (ctl.div_step) begin
			dv_q  <= dv_n;
			rem_q <= rem_n;
		end
	end

	// floor of the signed quotient
	assign qs  = $signed(dv_q[MID_W-1:0]);
	assign res = neg_q ? -qs - MID_W'(rem_q != '0) : qs;

	// clamp to 32 bits
	always_comb begin
		if (res[MID_W-1:VAL_W-1] == '0 || res[MID_W-1:VAL_W-1] == '1)
			res_sat = res[VAL_W-1:0];
		else if (res[MID_W-1])
			res_sat = {1'b1, {(VAL_W-1){1'b0}}};
		else
			res_sat = {1'b0, {(VAL_W-1){1'b1}}};
	end

endmodule

### rtl/periodic_tricubic_upsampler.sv
// Top level of the periodic tricubic upsampler: sequencer, grid RAM, two lanes.
// Depends on tcu_pkg, tcu_if, tcu_ram and tcu_lane.
`timescale 1ns / 1ps
//
// Usage
//  item channel (valid/ready): op 0 stores energy_in/weight_in at the coarse
//  point (coord_x, coord_y, coord_z); op 1 expands the named coarse cell.
//  result channel (valid/ready): f^3 words per expand, x outermost, z
//  innermost, last set on the final word. A load gives no word.
//  Config port: cfg_we writes cfg_data to register cfg_index (sizes, factor);
//  write only while the block is idle.
//  An expand reduces the cell index modulo the axis sizes, gathers 64
//  neighbors from the grid RAM, then computes 16f + 4f^2 + f^3 dot products,
//  each a MAC phase and a divide followed by a write-back or an output word,
//  on the shared MAC and the 8-bit-per-cycle divider.
//  Item ready is high only while idle. A result waits in an output
//  register; while the receiver stalls, the sequencer holds before the
//  next word. The final word may still wait while the next item is taken.
//  Reset clears control and restores the register defaults; grid contents
//  are undefined until loaded.

module periodic_tricubic_upsampler import tcu_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	tcu_item_if.sink               item,
	tcu_result_if.source           result
);

	// configuration
	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [FAC_W-1:0]  factor_q;
	logic [SIZE_W-1:0] nx, ny, nz;
	logic [FAC_W-1:0]  fe;
	logic [1:0]        fm1;
	logic [DEN_W-1:0]  f8, den;

	// sequencer
	state_t            state_q, state_n;
	pass_t             pass_q;
	logic [AXIS_W-1:0] cx_q, cy_q, cz_q;
	logic [AXIS_W-1:0] sx_q, sy_q, sz_q;
	logic [AXIS_W-1:0] gx_q, gy_q, gz_q;
	logic [NB_W:0]     g_q;
	logic [2:0]        m_q;
	logic [2:0]        dcnt_q;
	logic [1:0]        jx_q, jy_q, jz_q, k_q, l_q, jsel;
	logic              gwe_q;
	logic [NB_W-1:0]   gwaddr_q;
	logic              in_range, out_free, all_last, load_acc, exp_acc;
	ctl_t              ctl;

	// grid and lanes
	logic [2*VAL_W-1:0]       grid_rd;
	logic signed [VAL_W-1:0]  e_sat, w_sat;
	logic                     out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_W'(AXIS_MAX);
			size_y_q <= SIZE_W'(AXIS_MAX);
			size_z_q <= SIZE_W'(AXIS_MAX);
			factor_q <= FAC_W'(2);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SIZE_X: size_x_q <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Y: size_y_q <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Z: size_z_q <= cfg_data[SIZE_W-1:0];
				REG_FACTOR: factor_q <= cfg_data[FAC_W-1:0];
				default: ;
			endcase
		end
	end

	assign nx  = eff_size(size_x_q);
	assign ny  = eff_size(size_y_q);
	assign nz  = eff_size(size_z_q);
	assign fe  = eff_factor(factor_q);
	assign fm1 = 2'(fe - FAC_W'(1));
	assign f8  = DEN_W'(fe);
	assign den = DEN_W'(f8 * f8 * f8 * DEN_W'(2));

	assign item.ready = (state_q == ST_IDLE);
	assign load_acc   = item.valid && item.ready && !item.op;
	assign exp_acc    = item.valid && item.ready && item.op;
	assign in_range   = (SIZE_W'(cx_q) < nx) && (SIZE_W'(cy_q) < ny) && (SIZE_W'(cz_q) < nz);
	assign out_free   = !out_valid_q || result.ready;
	assign all_last   = (jx_q == fm1) && (jy_q == fm1) && (jz_q == fm1);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: if (exp_acc) state_n = ST_WRAP;
			ST_WRAP: if (in_range) state_n = ST_GATHER;
			ST_GATHER: if (g_q[NB_W]) state_n = ST_MAC;
			ST_MAC: if (m_q == 3'd5) state_n = ST_DIV;
			ST_DIV: begin
				if (dcnt_q == 3'(DIV_STEPS))
					state_n = (pass_q == PASS_Z) ? ST_EMIT : ST_STORE;
			end
			ST_STORE: state_n = ST_MAC;
			ST_EMIT: if (out_free) state_n = all_last ? ST_IDLE : ST_MAC;
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	// sequencer counters and indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= PASS_X;
			cx_q <= '0; cy_q <= '0; cz_q <= '0;
			sx_q <= '0; sy_q <= '0; sz_q <= '0;
			gx_q <= '0; gy_q <= '0; gz_q <= '0;
			g_q <= '0; m_q <= '0; dcnt_q <= '0;
			jx_q <= '0; jy_q <= '0; jz_q <= '0; k_q <= '0; l_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (exp_acc) begin
						cx_q <= item.coord_x;
						cy_q <= item.coord_y;
						cz_q <= item.coord_z;
					end
				end
				ST_WRAP: begin
					// reduce the cell index modulo the axis size, one subtract per cycle
					if (SIZE_W'(cx_q) >= nx) cx_q <= cx_q - AXIS_W'(nx);
					if (SIZE_W'(cy_q) >= ny) cy_q <= cy_q - AXIS_W'(ny);
					if (SIZE_W'(cz_q) >= nz) cz_q <= cz_q - AXIS_W'(nz);
					if (in_range) begin
						sx_q <= wrap_prev(cx_q, nx);
						sy_q <= wrap_prev(cy_q, ny);
						sz_q <= wrap_prev(cz_q, nz);
						gx_q <= wrap_prev(cx_q, nx);
						gy_q <= wrap_prev(cy_q, ny);
						gz_q <= wrap_prev(cz_q, nz);
						g_q  <= '0;
					end
				end
				ST_GATHER: begin
					if (!g_q[NB_W]) begin
						g_q <= g_q + (NB_W+1)'(1);
						if (g_q[1:0] != 2'd3) begin
							gz_q <= wrap_next(gz_q, nz);
						end else begin
							gz_q <= sz_q;
							if (g_q[3:2] != 2'd3) begin
								gy_q <= wrap_next(gy_q, ny);
							end else begin
								gy_q <= sy_q;
								gx_q <= wrap_next(gx_q, nx);
							end
						end
					end else begin
						pass_q <= PASS_X;
						jx_q <= '0; k_q <= '0; l_q <= '0; m_q <= '0;
					end
				end
				ST_MAC: begin
					m_q <= (m_q == 3'd5) ? 3'd0 : m_q + 3'd1;
					dcnt_q <= '0;
				end
				ST_DIV: dcnt_q <= dcnt_q + 3'd1;
				ST_STORE: begin
					m_q <= '0;
					if (pass_q == PASS_X) begin
						if ({k_q, l_q} == 4'hF) begin
							pass_q <= PASS_Y;
							jy_q <= '0;
							l_q <= '0;
						end else begin
							{k_q, l_q} <= {k_q, l_q} + 4'd1;
						end
					end else begin
						if (l_q == 2'd3) begin
							pass_q <= PASS_Z;
							jz_q <= '0;
						end else begin
							l_q <= l_q + 2'd1;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_q <= '0;
						if (jz_q != fm1) begin
							jz_q <= jz_q + 2'd1;
						end else if (jy_q != fm1) begin
							jy_q <= jy_q + 2'd1;
							pass_q <= PASS_Y;
							l_q <= '0;
						end else if (jx_q != fm1) begin
							jx_q <= jx_q + 2'd1;
							pass_q <= PASS_X;
							k_q <= '0;
							l_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// gather write-back: enable and address are registered to line up with the RAM's registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gwe_q <= 1'b0;
			gwaddr_q <= '0;
		end else begin
			gwe_q <= (state_q == ST_GATHER) && !g_q[NB_W];
			gwaddr_q <= g_q[NB_W-1:0];
		end
	end

	// lane control word
	always_comb begin
		case (pass_q)
			PASS_X: jsel = jx_q;
			PASS_Y: jsel = jy_q;
			default: jsel = jz_q;
		endcase
		ctl          = '0;
		ctl.nb_we    = gwe_q;
		ctl.nb_waddr = gwaddr_q;
		ctl.nb_raddr = {m_q[1:0], k_q, l_q};
		ctl.pass     = pass_q;
		ctl.issue    = (state_q == ST_MAC) && !m_q[2];
		ctl.first    = (m_q == 3'd0);
		ctl.wgt      = catmull_weight(fe, jsel, m_q[1:0]);
		ctl.div_load = (state_q == ST_DIV) && (dcnt_q == 3'd0);
		ctl.div_step = (state_q == ST_DIV) && (dcnt_q != 3'd0);
		ctl.den      = den;
		ctl.store    = (state_q == ST_STORE);
		case (state_q)
			ST_MAC: ctl.sel_idx = (pass_q == PASS_Y) ? {m_q[1:0], l_q} : {2'b00, m_q[1:0]};
			default: ctl.sel_idx = (pass_q == PASS_X) ? {k_q, l_q} : {2'b00, l_q};
		endcase
	end

	tcu_ram #(
		.DATA_W(2 * VAL_W),
		.ADDR_W(ADDR_W)
	) u_grid (
		.clk  (clk),
		.we   (load_acc),
		.waddr({item.coord_x, item.coord_y, item.coord_z}),
		.wdata({item.energy_in, item.weight_in}),
		.raddr({gx_q, gy_q, gz_q}),
		.rdata(grid_rd)
	);

	tcu_lane u_energy (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.grid_rd(grid_rd[2*VAL_W-1:VAL_W]),
		.res_sat(e_sat)
	);

	tcu_lane u_weight (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.grid_rd(grid_rd[VAL_W-1:0]),
		.res_sat(w_sat)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_EMIT && out_free)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			result.fine_x     <= FINE_W'({2'b00, cx_q} * {3'b000, fe} + {4'b0000, jx_q});
			result.fine_y     <= FINE_W'({2'b00, cy_q} * {3'b000, fe} + {4'b0000, jy_q});
			result.fine_z     <= FINE_W'({2'b00, cz_q} * {3'b000, fe} + {4'b0000, jz_q});
			result.energy_out <= e_sat;
			result.weight_out <= w_sat;
			result.last       <= all_last;
		end
	end

	assign result.valid = out_valid_q;

endmodule

### rtl/tcu_checker.sv
// Port-level assertions for the tricubic upsampler, bound to its top level.
// Depends on periodic_tricubic_upsampler.
`timescale 1ns / 1ps

module tcu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_op,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_last,
	input logic [31:0] out_energy
);

	// a pending word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_energy))
		else $error("result word changed while stalled");

	// an accepted expand keeps the block busy
	a_expand_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_op |=> !in_ready)
		else $error("input taken right after an expand");

	// nothing follows the final word of an expand at once
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid)
		else $error("word emitted right after last");

endmodule

bind periodic_tricubic_upsampler tcu_checker u_tcu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.in_op     (item.op),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_last  (result.last),
	.out_energy(result.energy_out)
);
